### rtl/patch_display_ratchet_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the patch display ratchet
// Concurrent checks clocked on clk_i; compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef PATCH_DISPLAY_RATCHET_DEFINES_SVH
`define PATCH_DISPLAY_RATCHET_DEFINES_SVH

`ifndef ASSERT_OFF
// Check sampled on every rising edge, skipped while reset is asserted.
`define PDR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Check sampled on every rising edge, reset included.
`define PDR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define PDR_ASSERT(lbl, prop, msg)
`define PDR_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### rtl/pdr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdr_pkg
// Shared constants, register codes and types of the patch display ratchet.
// ----------------------------------------------------------------------------
package pdr_pkg;

  localparam logic [15:0] ONE_Q15 = 16'h8000;
  localparam logic [15:0] ONE_Q12 = 16'h1000;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [15:0] EMA_ALPHA_RST     = 16'd8192;
  localparam logic [15:0] LOCKED_GAIN_RST   = 16'd8192;
  localparam logic [15:0] RECOVERY_GAIN_RST = 16'd8192;
  localparam logic [15:0] LOCAL_WEIGHT_RST  = 16'd16384;
  localparam logic [15:0] GLOBAL_WEIGHT_RST = 16'd16384;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EMA_ALPHA     = 3'd0,
    CFG_LOCKED_GAIN   = 3'd1,
    CFG_RECOVERY_GAIN = 3'd2,
    CFG_LOCAL_WEIGHT  = 3'd3,
    CFG_GLOBAL_WEIGHT = 3'd4
  } cfg_reg_e;

  // Decoded configuration, ready for the datapath
  typedef struct packed {
    logic [15:0] alpha;
    logic [15:0] alpha_inv;
    logic [15:0] locked_gain;
    logic [15:0] recovery_gain;
    logic        color_en;
  } cfg_t;

  // Per-transaction sideband that rides along the growth stages
  typedef struct packed {
    logic [15:0] pd;
    logic [15:0] ema;
    logic        warm;
    logic        seen_pos;
  } side_t;

  function automatic logic [15:0] clamp_one(input logic [15:0] v);
    return (v > ONE_Q15) ? ONE_Q15 : v;
  endfunction

  function automatic logic [15:0] floor_one_q12(input logic [15:0] g);
    return (g < ONE_Q12) ? ONE_Q12 : g;
  endfunction

endpackage

### rtl/pdr_intf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Patch display ratchet channels
// Valid/ready channels for patch records in and display results out.
// ----------------------------------------------------------------------------
interface pdr_in_if;
  logic               valid;
  logic               ready;
  logic [15:0]        prior_display;
  logic [15:0]        prior_average;
  logic signed [31:0] seen_count;
  logic [15:0]        goal_level;
  logic               locked_flag;
  logic [15:0]        ghost_level;

  modport source (
    output valid, prior_display, prior_average, seen_count, goal_level,
           locked_flag, ghost_level,
    input  ready
  );
  modport sink (
    input  valid, prior_display, prior_average, seen_count, goal_level,
           locked_flag, ghost_level,
    output ready
  );
endinterface

interface pdr_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] new_display;
  logic [15:0] new_average;
  logic [15:0] color_level;
  logic        warm_started;

  modport source (
    output valid, new_display, new_average, color_level, warm_started,
    input  ready
  );
  modport sink (
    input  valid, new_display, new_average, color_level, warm_started,
    output ready
  );
endinterface

### rtl/patch_display_ratchet.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// patch_display_ratchet
// Per-patch display update: EMA toward the goal, ratcheted display with
// locked and warm-start growth acceleration, and color evidence.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one patch record per transaction, out_ch one result per
//   record, in order. cfg_we_i/cfg_idx_i/cfg_wdata_i write the five registers
//   (alpha, locked gain, recovery gain, local and global weight); write them
//   only while no transaction is in flight.
//   A record reaches out_ch through seven register stages: three front
//   stages (clamp, EMA products, EMA round) and two stages in each of the
//   two growth accelerators, each of which holds one 16x16 multiply.
//   One transaction per cycle unless out_ch stalls; all stages move together.
//   Reset empties the pipeline and loads the register defaults.
//   When the receiver stalls with a result waiting, every stage holds,
//   bubbles included, and in_ch.ready stays low until out_ch.ready returns.
// ----------------------------------------------------------------------------
`include "patch_display_ratchet_defines.svh"

module patch_display_ratchet (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pdr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [15:0]                   cfg_wdata_i,
  pdr_in_if.sink                        in_ch,
  pdr_out_if.source                     out_ch
);

  pdr_pkg::cfg_t  cfg;
  logic           adv;
  logic           ema_valid, acc1_valid, acc2_valid;
  logic [15:0]    ema_base, ema_growth;
  pdr_pkg::side_t ema_side, acc1_side, acc2_side;
  logic [15:0]    acc1_res, acc2_res;
  logic [15:0]    rec_base, rec_growth;
  logic           rec_grow;

  // advance whenever the output slot is empty or being taken
  assign adv         = !acc2_valid || out_ch.ready;
  assign in_ch.ready = adv;

  pdr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  pdr_ema u_ema (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .adv_i           (adv),
    .valid_i         (in_ch.valid),
    .prior_display_i (in_ch.prior_display),
    .prior_average_i (in_ch.prior_average),
    .seen_count_i    (in_ch.seen_count),
    .goal_level_i    (in_ch.goal_level),
    .locked_flag_i   (in_ch.locked_flag),
    .ghost_level_i   (in_ch.ghost_level),
    .cfg_i           (cfg),
    .valid_o         (ema_valid),
    .base_o          (ema_base),
    .growth_o        (ema_growth),
    .side_o          (ema_side)
  );

  pdr_accel u_locked (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .valid_i  (ema_valid),
    .base_i   (ema_base),
    .growth_i (ema_growth),
    .gain_i   (cfg.locked_gain),
    .side_i   (ema_side),
    .valid_o  (acc1_valid),
    .result_o (acc1_res),
    .side_o   (acc1_side)
  );

  // recovery growth only after a warm start with a positive count
  always_comb begin
    rec_grow   = acc1_side.warm && acc1_side.seen_pos && (acc1_res > acc1_side.pd);
    rec_base   = rec_grow ? acc1_side.pd : acc1_res;
    rec_growth = rec_grow ? (acc1_res - acc1_side.pd) : 16'd0;
  end

  pdr_accel u_recovery (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .valid_i  (acc1_valid),
    .base_i   (rec_base),
    .growth_i (rec_growth),
    .gain_i   (cfg.recovery_gain),
    .side_i   (acc1_side),
    .valid_o  (acc2_valid),
    .result_o (acc2_res),
    .side_o   (acc2_side)
  );

  assign out_ch.valid        = acc2_valid;
  assign out_ch.new_display  = acc2_res;
  assign out_ch.new_average  = acc2_side.ema;
  assign out_ch.color_level  = cfg.color_en ? acc2_res : 16'd0;
  assign out_ch.warm_started = acc2_side.warm;

  `PDR_ASSERT_ALWAYS(a_disp_sat, out_ch.valid |-> (out_ch.new_display <= pdr_pkg::ONE_Q15), "display above one")
  `PDR_ASSERT(a_disp_ratchet, out_ch.valid |-> (out_ch.new_display >= acc2_side.pd), "display fell below previous display")
  `PDR_ASSERT(a_color_sel, out_ch.valid |-> ((out_ch.color_level == 16'd0) || (out_ch.color_level == out_ch.new_display)), "color neither zero nor display")
  `PDR_ASSERT(a_warm_ghost, (out_ch.valid && out_ch.warm_started) |-> (acc2_side.pd != 16'd0), "warm start without a ghost level")

endmodule

### rtl/pdr_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdr_cfg
// Configuration registers and their decoded, clamped form.
// ----------------------------------------------------------------------------
module pdr_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pdr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [15:0]                   cfg_wdata_i,
  output pdr_pkg::cfg_t                 cfg_o
);

  logic [15:0] alpha_q, locked_q, recovery_q, local_q, global_q;
  logic [15:0] alpha_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q    <= pdr_pkg::EMA_ALPHA_RST;
      locked_q   <= pdr_pkg::LOCKED_GAIN_RST;
      recovery_q <= pdr_pkg::RECOVERY_GAIN_RST;
      local_q    <= pdr_pkg::LOCAL_WEIGHT_RST;
      global_q   <= pdr_pkg::GLOBAL_WEIGHT_RST;
    end else if (cfg_we_i) begin
      case (pdr_pkg::cfg_reg_e'(cfg_idx_i))
        pdr_pkg::CFG_EMA_ALPHA:     alpha_q    <= cfg_wdata_i;
        pdr_pkg::CFG_LOCKED_GAIN:   locked_q   <= cfg_wdata_i;
        pdr_pkg::CFG_RECOVERY_GAIN: recovery_q <= cfg_wdata_i;
        pdr_pkg::CFG_LOCAL_WEIGHT:  local_q    <= cfg_wdata_i;
        pdr_pkg::CFG_GLOBAL_WEIGHT: global_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    alpha_c             = pdr_pkg::clamp_one(alpha_q);
    cfg_o.alpha         = alpha_c;
    cfg_o.alpha_inv     = pdr_pkg::ONE_Q15 - alpha_c;
    cfg_o.locked_gain   = pdr_pkg::floor_one_q12(locked_q);
    cfg_o.recovery_gain = pdr_pkg::floor_one_q12(recovery_q);
    // negative weights count as zero, so only a positive weight enables color
    cfg_o.color_en      = (!local_q[15] && (local_q[14:0] != 15'd0)) ||
                          (!global_q[15] && (global_q[14:0] != 15'd0));
  end

endmodule

### rtl/pdr_ema.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdr_ema
// Front stages: input clamp and warm start, EMA products, EMA rounding and
// selection of the locked growth operands.
// ----------------------------------------------------------------------------
module pdr_ema (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               valid_i,
  input  logic [15:0]        prior_display_i,
  input  logic [15:0]        prior_average_i,
  input  logic signed [31:0] seen_count_i,
  input  logic [15:0]        goal_level_i,
  input  logic               locked_flag_i,
  input  logic [15:0]        ghost_level_i,
  input  pdr_pkg::cfg_t      cfg_i,
  output logic               valid_o,
  output logic [15:0]        base_o,
  output logic [15:0]        growth_o,
  output pdr_pkg::side_t     side_o
);

  // stage 1: clamped operands
  logic        v1_q;
  logic [15:0] pd1_q, pe1_q, goal1_q;
  logic        warm1_q, seen1_q, lock1_q;
  logic [15:0] pd1_d, pe1_d, ghost_c;
  logic        warm1_d, seen1_d;

  // stage 2: products
  logic        v2_q;
  logic [31:0] prod_g_q, prod_p_q;
  logic [15:0] pd2_q;
  logic        warm2_q, seen2_q, lock2_q;

  // stage 3: EMA and locked operands
  logic        v3_q;
  logic [15:0] base3_q, growth3_q, base3_d, growth3_d;
  pdr_pkg::side_t side3_q, side3_d;
  logic [32:0] ema_sum;
  logic [17:0] ema_raw;
  logic [15:0] ema_c;

  always_comb begin
    ghost_c = pdr_pkg::clamp_one(ghost_level_i);
    warm1_d = (prior_display_i == 16'd0) && (ghost_c != 16'd0);
    pd1_d   = warm1_d ? ghost_c : pdr_pkg::clamp_one(prior_display_i);
    pe1_d   = warm1_d ? ghost_c : pdr_pkg::clamp_one(prior_average_i);
    seen1_d = !seen_count_i[31] && (seen_count_i[30:0] != 31'd0);
  end

  always_comb begin
    ema_sum = {1'b0, prod_g_q} + {1'b0, prod_p_q} + 33'd16384;
    ema_raw = ema_sum[32:15];
    ema_c   = (ema_raw > {2'b00, pdr_pkg::ONE_Q15}) ? pdr_pkg::ONE_Q15 : ema_raw[15:0];

    side3_d.pd       = pd2_q;
    side3_d.ema      = ema_c;
    side3_d.warm     = warm2_q;
    side3_d.seen_pos = seen2_q;

    // locked: grow from the previous display; otherwise take the max, no growth
    if (lock2_q) begin
      base3_d   = pd2_q;
      growth3_d = (ema_c > pd2_q) ? (ema_c - pd2_q) : 16'd0;
    end else begin
      base3_d   = (ema_c > pd2_q) ? ema_c : pd2_q;
      growth3_d = 16'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      pd1_q     <= pd1_d;
      pe1_q     <= pe1_d;
      goal1_q   <= pdr_pkg::clamp_one(goal_level_i);
      warm1_q   <= warm1_d;
      seen1_q   <= seen1_d;
      lock1_q   <= locked_flag_i;

      prod_g_q  <= cfg_i.alpha * goal1_q;
      prod_p_q  <= cfg_i.alpha_inv * pe1_q;
      pd2_q     <= pd1_q;
      warm2_q   <= warm1_q;
      seen2_q   <= seen1_q;
      lock2_q   <= lock1_q;

      base3_q   <= base3_d;
      growth3_q <= growth3_d;
      side3_q   <= side3_d;
    end
  end

  assign valid_o  = v3_q;
  assign base_o   = base3_q;
  assign growth_o = growth3_q;
  assign side_o   = side3_q;

endmodule

### rtl/pdr_accel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdr_accel
// Two-stage growth accelerator: base + round(growth * gain / 4096),
// saturated at one. Sideband is carried alongside.
// ----------------------------------------------------------------------------
module pdr_accel (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           adv_i,
  input  logic           valid_i,
  input  logic [15:0]    base_i,
  input  logic [15:0]    growth_i,
  input  logic [15:0]    gain_i,
  input  pdr_pkg::side_t side_i,
  output logic           valid_o,
  output logic [15:0]    result_o,
  output pdr_pkg::side_t side_o
);

  logic           va_q, vb_q;
  logic [31:0]    prod_q;
  logic [15:0]    base_a_q;
  pdr_pkg::side_t side_a_q, side_b_q;
  logic [15:0]    res_q, res_d;
  logic [32:0]    rnd;
  logic [21:0]    total;

  always_comb begin
    rnd   = {1'b0, prod_q} + 33'd2048;
    total = {1'b0, rnd[32:12]} + {6'd0, base_a_q};
    res_d = (total > {6'd0, pdr_pkg::ONE_Q15}) ? pdr_pkg::ONE_Q15 : total[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (adv_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prod_q   <= growth_i * gain_i;
      base_a_q <= base_i;
      side_a_q <= side_i;
      res_q    <= res_d;
      side_b_q <= side_a_q;
    end
  end

  assign valid_o  = vb_q;
  assign result_o = res_q;
  assign side_o   = side_b_q;

endmodule
